FILE: hdl/qid_pkg.sv
// Shared types and constants for the quadtree image decoder.
// No dependencies.
package qid_pkg;

   localparam int LVL_W = 4;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } qid_op_type;

   typedef enum logic [2:0] {
      ST_TAKEN   = 3'd0,
      ST_REFUSED = 3'd1,
      ST_PIXEL   = 3'd2,
      ST_NEED    = 3'd3,
      ST_DONE    = 3'd4,
      ST_LEVEL   = 3'd5,
      ST_RSV6    = 3'd6,
      ST_RSV7    = 3'd7
   } qid_status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_NODE,
      FSM_PREAD,
      FSM_FIELD,
      FSM_RESP
   } qid_state_type;

   typedef struct packed {
      logic clear_all;
      logic load;
      logic shift;
      logic clear_field;
   } qid_bs_ctl_type;

   typedef struct packed {
      logic       has_bits;
      logic [7:0] acc;
      logic [3:0] cnt;
   } qid_bs_sts_type;

endpackage

FILE: hdl/qid_if.sv
// Request and response channel interfaces of the quadtree image decoder.
// No dependencies.
interface qid_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   modport source (output valid, opcode, data_byte, input ready);
   modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface qid_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic [2:0] status;
   logic       last_pixel;
   modport source (output valid, pixel, status, last_pixel, input ready);
   modport sink (input valid, pixel, status, last_pixel, output ready);
endinterface

FILE: hdl/quadtree_image_decoder.sv
// Quadtree image decoder top level: command decode, node sequencer, leaf output.
// Push, start and refused commands: the result is offered in the cycle after acceptance;
// a new word is taken only after the response has drained.
// Pull: each node that needs a parent read (uniform-covered nodes included) passes NODE then
// PREAD; coded bits and finished fields are handled in FIELD; when bits run out, NEED is returned.
// Synchronous active-high reset clears all control state; the node store is not cleared.
module quadtree_image_decoder #(
   parameter int MAX_LEVELS = 8
) (
   input  logic      clock,
   input  logic      reset,
   qid_req_if.sink   req_if,
   qid_rsp_if.source rsp_if
);
   localparam int POS_W = 2 * MAX_LEVELS + 1;
   localparam int AW    = 2 * MAX_LEVELS - 1;
   localparam int DEPTH = ((1 << (2 * MAX_LEVELS)) - 1) / 3;

   qid_pkg::qid_state_type state_ff, state_in;
   logic [qid_pkg::LVL_W-1:0] level_ff, level_in;
   logic                  hdr_ff, hdr_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [1:0]            phase_ff, phase_in;
   logic [10:0]           entry_ff, entry_in;
   logic [7:0]            sib_ff [0:2];
   logic [7:0]            sib_in [0:2];
   logic [POS_W-1:0]      leaf_ff, leaf_in;
   logic [7:0]            pix_ff, pix_in;
   qid_pkg::qid_status_type stat_ff, stat_in;
   logic                  last_ff, last_in;

   qid_pkg::qid_bs_ctl_type bs_ctl;
   qid_pkg::qid_bs_sts_type bs_sts;

   logic          wr_en, rd_en;
   logic [10:0]   wr_data, pe;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [POS_W-1:0] total_w, first_w, pos_m1;
   logic             accept, pos_zero, is_leaf, c3_new, f_done, f_complete;
   logic             root_only, p_deliver, f_deliver, img_done;
   logic [3:0]       need;
   logic [7:0]       m4, adv_mean;
   logic [10:0]      f_entry;
   logic             do_adv, do_deliver;
   qid_pkg::qid_op_type op;

   qid_bitser u_bitser (
      .clock     (clock),
      .reset     (reset),
      .ctl       (bs_ctl),
      .data_byte (req_if.data_byte),
      .sts       (bs_sts)
   );

   qid_store #(.AW(AW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (pe)
   );

   always_comb begin
      first_w = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         first_w[2*i] = (i < int'(level_ff));
      end
   end

   assign op        = qid_pkg::qid_op_type'(req_if.opcode);
   assign accept    = req_if.valid && req_if.ready;
   assign total_w   = POS_W'(1) << {level_ff, 1'b0};
   assign img_done  = (leaf_ff >= total_w);
   assign pos_m1    = pos_ff - POS_W'(1);
   assign pos_zero  = (pos_ff == '0);
   assign is_leaf   = (pos_ff >= first_w);
   assign c3_new    = (pos_m1[1:0] == 2'd3) && (phase_ff == 2'd0);
   assign m4        = {pe[8:3], pe[2:1]} - sib_ff[0] - sib_ff[1] - sib_ff[2];
   assign need      = (phase_ff == 2'd0) ? 4'd8 : (phase_ff == 2'd1) ? 4'd2 : 4'd1;
   assign f_done    = (bs_sts.cnt == need);
   assign f_complete = f_done && ((phase_ff == 2'd2) ||
                      ((phase_ff == 2'd1) && (bs_sts.acc[1:0] != 2'd0)));
   assign root_only = pos_zero && (level_ff == '0);
   assign p_deliver = pe[0] ? is_leaf : (c3_new && is_leaf);
   assign f_deliver = (f_done && (phase_ff == 2'd0) && !pos_zero && is_leaf) ||
                      (f_complete && root_only);
   assign f_entry   = (phase_ff == 2'd1) ? {entry_ff[10:3], bs_sts.acc[1:0], 1'b0}
                                         : {entry_ff[10:1], bs_sts.acc[0]};
   assign rd_addr   = pos_m1[AW+1:2];
   assign wr_addr   = pos_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qid_pkg::FSM_IDLE: begin
            if (accept) begin
               if (op == qid_pkg::OP_PULL && hdr_ff && !img_done) begin
                  state_in = qid_pkg::FSM_NODE;
               end else begin
                  state_in = qid_pkg::FSM_RESP;
               end
            end
         end
         qid_pkg::FSM_NODE: begin
            state_in = pos_zero ? qid_pkg::FSM_FIELD : qid_pkg::FSM_PREAD;
         end
         qid_pkg::FSM_PREAD: begin
            if (p_deliver) begin
               state_in = qid_pkg::FSM_RESP;
            end else if (pe[0]) begin
               state_in = qid_pkg::FSM_NODE;
            end else begin
               state_in = qid_pkg::FSM_FIELD;
            end
         end
         qid_pkg::FSM_FIELD: begin
            if (f_deliver) begin
               state_in = qid_pkg::FSM_RESP;
            end else if (f_complete) begin
               state_in = qid_pkg::FSM_NODE;
            end else if (!f_done && !bs_sts.has_bits) begin
               state_in = qid_pkg::FSM_RESP;
            end
         end
         qid_pkg::FSM_RESP: begin
            if (rsp_if.ready) begin
               state_in = qid_pkg::FSM_IDLE;
            end
         end
         default: state_in = qid_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      level_in   = level_ff;
      hdr_in     = hdr_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      entry_in   = entry_ff;
      sib_in     = sib_ff;
      leaf_in    = leaf_ff;
      pix_in     = pix_ff;
      stat_in    = stat_ff;
      last_in    = last_ff;
      bs_ctl     = '0;
      wr_en      = 1'b0;
      wr_data    = entry_ff;
      rd_en      = 1'b0;
      do_adv     = 1'b0;
      do_deliver = 1'b0;
      adv_mean   = 8'd0;
      unique case (state_ff)
         qid_pkg::FSM_IDLE: begin
            if (accept) begin
               pix_in  = 8'd0;
               last_in = 1'b0;
               stat_in = qid_pkg::ST_TAKEN;
               unique case (op)
                  qid_pkg::OP_PUSH: begin
                     if (!hdr_ff) begin
                        if (req_if.data_byte > 8'(MAX_LEVELS)) begin
                           stat_in = qid_pkg::ST_LEVEL;
                        end else begin
                           level_in = req_if.data_byte[qid_pkg::LVL_W-1:0];
                           hdr_in   = 1'b1;
                        end
                     end else if (bs_sts.has_bits) begin
                        stat_in = qid_pkg::ST_REFUSED;
                     end else begin
                        bs_ctl.load = 1'b1;
                     end
                  end
                  qid_pkg::OP_PULL: begin
                     if (!hdr_ff) begin
                        stat_in = qid_pkg::ST_NEED;
                     end else if (img_done) begin
                        stat_in = qid_pkg::ST_DONE;
                     end
                  end
                  qid_pkg::OP_START: begin
                     bs_ctl.clear_all = 1'b1;
                     level_in = '0;
                     hdr_in   = 1'b0;
                     pos_in   = '0;
                     phase_in = 2'd0;
                     sib_in   = '{default: 8'd0};
                     leaf_in  = '0;
                  end
                  default: stat_in = qid_pkg::ST_REFUSED;
               endcase
            end
         end
         qid_pkg::FSM_NODE: begin
            rd_en = !pos_zero;
         end
         qid_pkg::FSM_PREAD: begin
            if (pe[0]) begin
               do_adv   = 1'b1;
               adv_mean = pe[10:3];
               if (is_leaf) begin
                  do_deliver = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {pe[10:3], 3'b001};
               end
            end else if (c3_new) begin
               if (is_leaf) begin
                  do_adv     = 1'b1;
                  do_deliver = 1'b1;
                  adv_mean   = m4;
               end else begin
                  entry_in = {m4, 3'b000};
                  phase_in = 2'd1;
               end
            end
         end
         qid_pkg::FSM_FIELD: begin
            if (f_done) begin
               bs_ctl.clear_field = 1'b1;
               if (phase_ff == 2'd0) begin
                  if (f_deliver) begin
                     do_adv     = 1'b1;
                     do_deliver = 1'b1;
                     adv_mean   = bs_sts.acc;
                  end else begin
                     entry_in = {bs_sts.acc, 3'b000};
                     phase_in = 2'd1;
                  end
               end else if (f_complete) begin
                  do_adv   = 1'b1;
                  adv_mean = f_entry[10:3];
                  if (root_only) begin
                     do_deliver = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = f_entry;
                  end
               end else begin
                  entry_in = f_entry;
                  phase_in = 2'd2;
               end
            end else if (bs_sts.has_bits) begin
               bs_ctl.shift = 1'b1;
            end else begin
               stat_in = qid_pkg::ST_NEED;
               pix_in  = 8'd0;
               last_in = 1'b0;
            end
         end
         qid_pkg::FSM_RESP: begin
         end
         default: begin
         end
      endcase
      if (do_adv) begin
         if (!pos_zero && pos_m1[1:0] != 2'd3) begin
            sib_in[pos_m1[1:0]] = adv_mean;
         end
         pos_in             = pos_ff + POS_W'(1);
         phase_in           = 2'd0;
         bs_ctl.clear_field = 1'b1;
      end
      if (do_deliver) begin
         leaf_in = leaf_ff + POS_W'(1);
         pix_in  = adv_mean;
         stat_in = qid_pkg::ST_PIXEL;
         last_in = (leaf_ff + POS_W'(1) == total_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qid_pkg::FSM_IDLE;
         level_ff <= '0;
         hdr_ff   <= 1'b0;
         pos_ff   <= '0;
         phase_ff <= 2'd0;
         sib_ff   <= '{default: 8'd0};
         leaf_ff  <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         hdr_ff   <= hdr_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         sib_ff   <= sib_in;
         leaf_ff  <= leaf_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      pix_ff   <= pix_in;
      stat_ff  <= stat_in;
      last_ff  <= last_in;
   end

   assign req_if.ready      = (state_ff == qid_pkg::FSM_IDLE);
   assign rsp_if.valid      = (state_ff == qid_pkg::FSM_RESP);
   assign rsp_if.pixel      = pix_ff;
   assign rsp_if.status     = stat_ff;
   assign rsp_if.last_pixel = last_ff;

`ifndef SYNTHESIS
   a_leaf_bound: assert property (@(posedge clock) disable iff (reset)
      leaf_ff <= total_w)
      else $error("leaf count beyond image size");
   a_store_inner: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> pos_ff < first_w)
      else $error("store write at leaf position");
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && stat_ff == qid_pkg::ST_PIXEL |-> leaf_ff != '0)
      else $error("pixel without leaf count");
   a_pull_header: assert property (@(posedge clock) disable iff (reset)
      state_ff == qid_pkg::FSM_NODE |-> hdr_ff)
      else $error("node decode without header");
`endif
endmodule

FILE: hdl/qid_bitser.sv
// Bit-serial field reader: byte buffer shifted out MSB first into a field accumulator.
// Depends on qid_pkg.
module qid_bitser (
   input  logic                    clock,
   input  logic                    reset,
   input  qid_pkg::qid_bs_ctl_type ctl,
   input  logic [7:0]              data_byte,
   output qid_pkg::qid_bs_sts_type sts
);
   logic [7:0] buf_ff, buf_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] acc_ff, acc_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      buf_in  = buf_ff;
      left_in = left_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      if (ctl.clear_all) begin
         buf_in  = 8'd0;
         left_in = 4'd0;
         acc_in  = 8'd0;
         cnt_in  = 4'd0;
      end else begin
         if (ctl.load) begin
            buf_in  = data_byte;
            left_in = 4'd8;
         end
         if (ctl.clear_field) begin
            acc_in = 8'd0;
            cnt_in = 4'd0;
         end else if (ctl.shift) begin
            acc_in  = {acc_ff[6:0], buf_ff[7]};
            cnt_in  = cnt_ff + 4'd1;
            buf_in  = {buf_ff[6:0], 1'b0};
            left_in = left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= 8'd0;
         left_ff <= 4'd0;
         acc_ff  <= 8'd0;
         cnt_ff  <= 4'd0;
      end else begin
         buf_ff  <= buf_in;
         left_ff <= left_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign sts.has_bits = (left_ff != 4'd0);
   assign sts.acc      = acc_ff;
   assign sts.cnt      = cnt_ff;

`ifndef SYNTHESIS
   a_shift_has_bits: assert property (@(posedge clock) disable iff (reset)
      ctl.shift && !ctl.clear_field && !ctl.clear_all |-> left_ff != 4'd0)
      else $error("shift with empty buffer");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8)
      else $error("field count overflow");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> left_ff == 4'd0)
      else $error("load over unread bits");
`endif
endmodule

FILE: hdl/qid_store.sv
// Inner node store: one write port, one registered read port.
// No dependencies.
module qid_store #(
   parameter int AW    = 15,
   parameter int DEPTH = 21845
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [10:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [10:0]   rd_data
);
   logic [10:0] mem [0:DEPTH-1];
   logic [10:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
